// ===== design/liu_pkg.sv =====
// Shared types, constants and helpers for the linear interpolation upsampler.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package liu_pkg;

  // Datapath and register widths
  localparam int DATA_W = 32;
  localparam int FAC_W = 6;
  localparam int MODE_W = 2;
  localparam int MAX_FACTOR = 32;

  // Remainder of a division by the factor stays below MAX_FACTOR
  localparam int REM_W = $clog2(MAX_FACTOR);

  // Step divider retires this many quotient bits per cycle
  localparam int DIV_RADIX_BITS = 4;
  localparam int DIV_CYCLES = DATA_W / DIV_RADIX_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

  // APB register map
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MODE = 1'b0;
  localparam logic REG_FACTOR = 1'b1;

  // Interpolation modes for the y coordinate
  typedef enum logic [MODE_W-1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_NEAREST = 2'd1,
    MODE_ZERO    = 2'd2
  } interp_mode_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVIDE,
    S_EMIT_PREV,
    S_EMIT_INTERP,
    S_EMIT_FINAL
  } ctrl_state_t;

  // Source of the next output beat
  typedef enum logic [1:0] {
    OSEL_PREV,
    OSEL_INTERP,
    OSEL_FINAL
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     in_ready;
    logic     capture;
    logic     div_step;
    logic     acc_step;
    logic     load;
    out_sel_t sel;
    logic     last;
    logic     commit;
  } liu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_fin;
    logic have_prev;
    logic cur_fin;
    logic out_free;
  } liu_sts_t;

  // Clamp the programmed factor into 1..MAX_FACTOR
  function automatic logic [FAC_W-1:0] eff_factor(input logic [FAC_W-1:0] f);
    logic [FAC_W-1:0] r;
    r = f;
    if (f == '0) begin
      r = FAC_W'(1);
    end else if (f > FAC_W'(MAX_FACTOR)) begin
      r = FAC_W'(MAX_FACTOR);
    end
    return r;
  endfunction

endpackage

// ===== design/liu_pt_in_if.sv =====
// Input point channel: valid/ready handshake with one (x, y, final) beat.
// Depends on liu_pkg for the field widths.
`timescale 1ns / 1ps

interface liu_pt_in_if;
  import liu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic                     final_point;

  modport source (output valid, point_x, point_y, final_point, input ready);
  modport sink (input valid, point_x, point_y, final_point, output ready);
endinterface

// ===== design/liu_pt_out_if.sv =====
// Output point channel: valid/ready handshake with one (x, y, run_end) beat.
// Depends on liu_pkg for the field widths.
`timescale 1ns / 1ps

interface liu_pt_out_if;
  import liu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_x;
  logic signed [DATA_W-1:0] out_y;
  logic                     run_end;

  modport source (output valid, out_x, out_y, run_end, input ready);
  modport sink (input valid, out_x, out_y, run_end, output ready);
endinterface

// ===== design/liu_regs.sv =====
// APB configuration registers: interpolation mode and upsample factor.
// Depends on liu_pkg for the register map.
`timescale 1ns / 1ps

module liu_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [liu_pkg::ADDR_W-1:0]   paddr,
  input  logic [liu_pkg::PDATA_W-1:0]  pwdata,
  output logic [liu_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [liu_pkg::MODE_W-1:0]   interp_mode,
  output logic [liu_pkg::FAC_W-1:0]    upsample_factor
);
  import liu_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  // Write the selected register on the access beat
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode     <= MODE_LINEAR;
      upsample_factor <= FAC_W'(4);
    end else if (wr_en) begin
      case (reg_sel)
        REG_MODE:   interp_mode <= pwdata[MODE_W-1:0];
        REG_FACTOR: upsample_factor <= pwdata[FAC_W-1:0];
        default:    ;
      endcase
    end
  end

  // Read back the stored value
  always_comb begin
    case (reg_sel)
      REG_MODE:   prdata = PDATA_W'(interp_mode);
      REG_FACTOR: prdata = PDATA_W'(upsample_factor);
      default:    prdata = '0;
    endcase
  end

endmodule

// ===== design/liu_ctrl.sv =====
// Sequencer for the upsampler: accept, divide, then walk the output beats.
// Depends on liu_pkg for the state, command and status types.
`timescale 1ns / 1ps

module liu_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [liu_pkg::FAC_W-1:0] fac,
  input  liu_pkg::liu_sts_t         sts,
  output liu_pkg::liu_cmd_t         cmd
);
  import liu_pkg::*;

  ctrl_state_t          state;
  ctrl_state_t          state_next;
  logic [FAC_W-1:0]     j;
  logic [FAC_W-1:0]     j_next;
  logic [DIV_CNT_W-1:0] dcnt;
  logic [DIV_CNT_W-1:0] dcnt_next;
  logic                 j_last;
  logic                 div_last;
  logic                 fac_one;

  assign j_last   = (j == fac - FAC_W'(1));
  assign div_last = (dcnt == DIV_CNT_W'(DIV_CYCLES - 1));
  assign fac_one  = (fac == FAC_W'(1));

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      dcnt  <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      dcnt  <= dcnt_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.in_valid) begin
          if (sts.have_prev) begin
            state_next = S_DIVIDE;
          end else if (sts.in_fin) begin
            state_next = S_EMIT_FINAL;
          end
        end
      end
      S_DIVIDE: begin
        if (div_last) begin
          state_next = S_EMIT_PREV;
        end
      end
      S_EMIT_PREV: begin
        if (sts.out_free) begin
          if (!fac_one) begin
            state_next = S_EMIT_INTERP;
          end else begin
            state_next = sts.cur_fin ? S_EMIT_FINAL : S_IDLE;
          end
        end
      end
      S_EMIT_INTERP: begin
        if (sts.out_free && j_last) begin
          state_next = sts.cur_fin ? S_EMIT_FINAL : S_IDLE;
        end
      end
      S_EMIT_FINAL: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands and counter updates
  always_comb begin
    cmd       = '0;
    cmd.sel   = OSEL_PREV;
    j_next    = j;
    dcnt_next = dcnt;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.capture  = sts.in_valid;
        dcnt_next    = '0;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + DIV_CNT_W'(1);
      end
      S_EMIT_PREV: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = OSEL_PREV;
          cmd.acc_step = 1'b1;
          cmd.last     = fac_one && !sts.cur_fin;
          cmd.commit   = fac_one && !sts.cur_fin;
          j_next       = FAC_W'(1);
        end
      end
      S_EMIT_INTERP: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.sel      = OSEL_INTERP;
          cmd.acc_step = 1'b1;
          cmd.last     = j_last && !sts.cur_fin;
          cmd.commit   = j_last && !sts.cur_fin;
          j_next       = j + FAC_W'(1);
        end
      end
      S_EMIT_FINAL: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = OSEL_FINAL;
          cmd.last   = 1'b1;
          cmd.commit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // A beat is only loaded when the output register can take it
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("output loaded while occupied");

  // The divider runs its full count before the first beat
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE && div_last) |=> state == S_EMIT_PREV)
    else $error("divide phase did not end on its last cycle");

  // A point with a stored predecessor always goes to the divider
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.capture && sts.have_prev) |=> (state == S_DIVIDE && dcnt == '0))
    else $error("segment did not start the divider");

endmodule

// ===== design/liu_dp.sv =====
// Datapath for the upsampler: stored point, step divider, step accumulator
// and the output register. Depends on liu_pkg and the two channel interfaces.
`timescale 1ns / 1ps

module liu_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [liu_pkg::FAC_W-1:0]  fac,
  input  logic [liu_pkg::MODE_W-1:0] mode,
  input  liu_pkg::liu_cmd_t          cmd,
  output liu_pkg::liu_sts_t          sts,
  liu_pt_in_if.sink                  pt_in,
  liu_pt_out_if.source               pt_out
);
  import liu_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DATA_W-1:0] dq;
  } div_state_t;

  typedef struct packed {
    logic [DATA_W-1:0] q;
    logic [REM_W-1:0]  rem;
  } acc_t;

  // Several restoring division steps of the magnitude by the factor
  function automatic div_state_t div_iter(input div_state_t s,
                                          input logic [FAC_W-1:0] f);
    div_state_t       r;
    logic [REM_W:0]   t;
    r = s;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      t    = {r.rem, r.dq[DATA_W-1]};
      r.dq = {r.dq[DATA_W-2:0], 1'b0};
      if ((FAC_W+1)'(t) >= (FAC_W+1)'(f)) begin
        r.rem   = REM_W'((FAC_W+1)'(t) - (FAC_W+1)'(f));
        r.dq[0] = 1'b1;
      end else begin
        r.rem = REM_W'(t);
      end
    end
    return r;
  endfunction

  // Advance |diff|*j/f to |diff|*(j+1)/f from the quotient and remainder
  function automatic acc_t acc_iter(input acc_t a, input div_state_t d,
                                    input logic [FAC_W-1:0] f);
    acc_t           r;
    logic [FAC_W:0] s;
    s = (FAC_W+1)'(a.rem) + (FAC_W+1)'(d.rem);
    if (s >= (FAC_W+1)'(f)) begin
      r.q   = a.q + d.dq + DATA_W'(1);
      r.rem = REM_W'(s - (FAC_W+1)'(f));
    end else begin
      r.q   = a.q + d.dq;
      r.rem = REM_W'(s);
    end
    return r;
  endfunction

  // Base plus the signed step, always back in range
  function automatic logic [DATA_W-1:0] apply_step(input logic [DATA_W-1:0] base,
                                                   input logic neg,
                                                   input logic [DATA_W-1:0] q);
    logic [DATA_W:0] off;
    logic [DATA_W:0] sum;
    off = neg ? -{1'b0, q} : {1'b0, q};
    sum = {base[DATA_W-1], base} + off;
    return sum[DATA_W-1:0];
  endfunction

  logic [DATA_W-1:0] prev_x;
  logic [DATA_W-1:0] prev_y;
  logic              have_prev;
  logic [DATA_W-1:0] cur_x;
  logic [DATA_W-1:0] cur_y;
  logic              cur_fin;
  logic              neg_x;
  logic              neg_y;
  div_state_t        div_x;
  div_state_t        div_y;
  acc_t              acc_x;
  acc_t              acc_y;
  logic              out_valid;
  logic [DATA_W-1:0] out_x;
  logic [DATA_W-1:0] out_y;
  logic              run_end;
  logic [DATA_W:0]   diff_x;
  logic [DATA_W:0]   diff_y;
  logic [DATA_W:0]   mag_x;
  logic [DATA_W:0]   mag_y;
  logic [DATA_W-1:0] ix;
  logic [DATA_W-1:0] iy;
  logic [DATA_W-1:0] ox;
  logic [DATA_W-1:0] oy;
  logic              out_free;

  // Segment differences against the stored point, exact in 33 bits
  assign diff_x = {pt_in.point_x[DATA_W-1], pt_in.point_x} - {prev_x[DATA_W-1], prev_x};
  assign diff_y = {pt_in.point_y[DATA_W-1], pt_in.point_y} - {prev_y[DATA_W-1], prev_y};
  assign mag_x  = diff_x[DATA_W] ? -diff_x : diff_x;
  assign mag_y  = diff_y[DATA_W] ? -diff_y : diff_y;

  assign out_free = !out_valid || pt_out.ready;

  assign pt_in.ready = cmd.in_ready;

  assign sts.in_valid  = pt_in.valid;
  assign sts.in_fin    = pt_in.final_point;
  assign sts.have_prev = have_prev;
  assign sts.cur_fin   = cur_fin;
  assign sts.out_free  = out_free;

  // Stored point of the series
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (cmd.capture && !have_prev) begin
      prev_x    <= pt_in.point_x;
      prev_y    <= pt_in.point_y;
      have_prev <= !pt_in.final_point;
    end else if (cmd.commit) begin
      prev_x    <= cur_x;
      prev_y    <= cur_y;
      have_prev <= !cur_fin;
    end
  end

  // Hold the accepted point, run the divider, step the accumulators
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x     <= pt_in.point_x;
      cur_y     <= pt_in.point_y;
      cur_fin   <= pt_in.final_point;
      neg_x     <= diff_x[DATA_W];
      neg_y     <= diff_y[DATA_W];
      div_x.rem <= '0;
      div_x.dq  <= mag_x[DATA_W-1:0];
      div_y.rem <= '0;
      div_y.dq  <= mag_y[DATA_W-1:0];
      acc_x     <= '0;
      acc_y     <= '0;
    end else begin
      if (cmd.div_step) begin
        div_x <= div_iter(div_x, fac);
        div_y <= div_iter(div_y, fac);
      end
      if (cmd.acc_step) begin
        acc_x <= acc_iter(acc_x, div_x, fac);
        acc_y <= acc_iter(acc_y, div_y, fac);
      end
    end
  end

  // Interpolated point for the current step
  assign ix = apply_step(prev_x, neg_x, acc_x.q);

  always_comb begin
    case (mode)
      MODE_NEAREST: iy = cur_y;
      MODE_ZERO:    iy = '0;
      default:      iy = apply_step(prev_y, neg_y, acc_y.q);
    endcase
  end

  // Pick the beat source
  always_comb begin
    case (cmd.sel)
      OSEL_PREV: begin
        ox = prev_x;
        oy = prev_y;
      end
      OSEL_INTERP: begin
        ox = ix;
        oy = iy;
      end
      OSEL_FINAL: begin
        ox = cur_x;
        oy = cur_y;
      end
      default: begin
        ox = cur_x;
        oy = cur_y;
      end
    endcase
  end

  // Output register: hold the beat until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (pt_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_x   <= ox;
      out_y   <= oy;
      run_end <= cmd.last;
    end
  end

  assign pt_out.valid   = out_valid;
  assign pt_out.out_x   = out_x;
  assign pt_out.out_y   = out_y;
  assign pt_out.run_end = run_end;

endmodule

// ===== design/linear_interp_upsampler.sv =====
// Top level of the linear interpolation upsampler.
// Depends on liu_pkg, the channel interfaces, liu_regs, liu_ctrl and liu_dp.
//
// Usage:
//   pt_in carries (point_x, point_y, final_point) beats, pt_out carries
//   (out_x, out_y, run_end) beats; both are valid/ready channels. The APB
//   port holds interp_mode at address 0 and upsample_factor at address 4.
//   The first point of a series is stored and, unless final, gives no beat.
//   Each later point gives the stored point and then F-1 interpolated
//   points, F being the factor clamped to 1..32; a final point adds itself
//   at the end with run_end set, and closes the series.
//   Sequence: an accepted point with a stored predecessor first runs through
//   the step divider (4 quotient bits per cycle over a 32-bit magnitude),
//   then loads one beat per cycle into the output register while that
//   register is free. The next point is accepted only once the sequencer
//   is back in idle, after the last beat of the item is loaded.
//   The output register holds its beat while pt_out.ready is low and the
//   sequencer waits; no beat is lost or repeated.
//   Reset clears the stored point and sets mode 0 (linear) and factor 4.
//   Write configuration only while the block is idle.
`timescale 1ns / 1ps

module linear_interp_upsampler (
  input  logic                         clk,
  input  logic                         rst,
  liu_pt_in_if.sink                    pt_in,
  liu_pt_out_if.source                 pt_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [liu_pkg::ADDR_W-1:0]   paddr,
  input  logic [liu_pkg::PDATA_W-1:0]  pwdata,
  output logic [liu_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import liu_pkg::*;

  logic [MODE_W-1:0] interp_mode;
  logic [FAC_W-1:0]  upsample_factor;
  logic [FAC_W-1:0]  fac;
  liu_cmd_t          cmd;
  liu_sts_t          sts;

  liu_regs u_regs (
    .clk             (clk),
    .rst             (rst),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .interp_mode     (interp_mode),
    .upsample_factor (upsample_factor)
  );

  // Clamp the factor once for both sides
  assign fac = eff_factor(upsample_factor);

  liu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .fac (fac),
    .sts (sts),
    .cmd (cmd)
  );

  liu_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .fac    (fac),
    .mode   (interp_mode),
    .cmd    (cmd),
    .sts    (sts),
    .pt_in  (pt_in),
    .pt_out (pt_out)
  );

endmodule

// ===== bench/linear_interp_upsampler_test.sv =====
// Self-checking bench for linear_interp_upsampler: streams (x, y) points through the
// input channel, predicts every upsampled beat and checks the output channel against it.
// Depends on liu_pkg, liu_pt_in_if, liu_pt_out_if and the block itself.
`timescale 1ns / 1ps

module linear_interp_upsampler_test;
  import liu_pkg::*;

  // Mode code with no enum member; the block treats it as linear
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int END_CYCLES = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_POINTS = 15;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic                     fin;
    int                       gap;
    bit                       drain;
  } in_pt_t;

  typedef struct {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic                     run_end;
  } out_pt_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  liu_pt_in_if  pt_in_ch ();
  liu_pt_out_if pt_out_ch ();

  linear_interp_upsampler dut (
    .clk     (clk),
    .rst     (rst),
    .pt_in   (pt_in_ch),
    .pt_out  (pt_out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Points waiting to be sent and beats waiting to arrive
  in_pt_t  points_q[$];
  out_pt_t expected_pts[$];

  // Shadow of the block's registers and stored point
  logic [MODE_W-1:0]        mode_cfg = MODE_LINEAR;
  logic [FAC_W-1:0]         factor_cfg = 6'd4;
  logic signed [DATA_W-1:0] prev_x = '0;
  logic signed [DATA_W-1:0] prev_y = '0;
  logic                     have_prev = 1'b0;

  // Handshake bookkeeping shared between the edges
  bit     calm = 1'b0;
  bit     pt_taken = 1'b0;
  bit     beat_taken = 1'b0;
  bit     pt_busy = 1'b0;
  bit     pt_up = 1'b0;
  in_pt_t cur_pt;
  int     gap_left = 0;
  int     ready_wait = 0;
  int     idle_run = 0;
  int     fail_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Point j of a segment: a + (b - a) * j / f, quotient truncated toward zero
  function automatic logic signed [DATA_W-1:0] interp_coord(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input int j,
    input int f
  );
    longint sa;
    longint span;
    longint v;
    sa = a;
    span = longint'(b) - sa;
    v = sa + (span * j) / f;
    return v[DATA_W-1:0];
  endfunction

  // Expand one accepted point into the beats it causes
  function automatic void predict_point(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] y,
    input logic fin
  );
    int      f;
    out_pt_t b;
    if (factor_cfg == 0) begin
      f = 1;
    end else if (factor_cfg > MAX_FACTOR) begin
      f = MAX_FACTOR;
    end else begin
      f = factor_cfg;
    end
    if (have_prev) begin
      b.x = prev_x;
      b.y = prev_y;
      b.run_end = (f == 1) && !fin;
      expected_pts.push_back(b);
      for (int j = 1; j < f; j++) begin
        b.x = interp_coord(prev_x, x, j, f);
        case (mode_cfg)
          MODE_NEAREST: begin
            b.y = y;
          end
          MODE_ZERO: begin
            b.y = '0;
          end
          default: begin
            b.y = interp_coord(prev_y, y, j, f);
          end
        endcase
        b.run_end = (j == f - 1) && !fin;
        expected_pts.push_back(b);
      end
    end
    if (fin) begin
      b.x = x;
      b.y = y;
      b.run_end = 1'b1;
      expected_pts.push_back(b);
    end
    prev_x = x;
    prev_y = y;
    have_prev = !fin;
  endfunction

  // Queue one point for the driver with a random lead-in gap, or none when calm
  function automatic void stage_pt(
    input logic signed [DATA_W-1:0] x,
    input logic signed [DATA_W-1:0] y,
    input logic fin,
    input bit drain
  );
    in_pt_t p;
    p.x = x;
    p.y = y;
    p.fin = fin;
    p.gap = calm ? 0 : $urandom_range(0, 9);
    p.drain = drain;
    points_q.push_back(p);
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic reg_write(input logic idx, input logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_MODE) begin
      mode_cfg = value[MODE_W-1:0];
    end else begin
      factor_cfg = value[FAC_W-1:0];
    end
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [FAC_W-1:0] factor);
    reg_write(REG_MODE, PDATA_W'(mode));
    reg_write(REG_FACTOR, PDATA_W'(factor));
  endtask

  // Wait until every point is sent and every beat has come, then let the block go quiet
  task automatic settle();
    while (points_q.size() != 0 || pt_busy || expected_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Drive input points at the falling edge; hold valid until the beat is taken
  always @(negedge clk) begin
    logic nv;
    nv = 1'b0;
    if (pt_taken) begin
      pt_taken = 1'b0;
      pt_busy = 1'b0;
      pt_up = 1'b0;
    end
    if (!pt_busy && points_q.size() != 0) begin
      cur_pt = points_q.pop_front();
      pt_busy = 1'b1;
      gap_left = cur_pt.gap;
    end
    if (pt_busy) begin
      if (pt_up) begin
        nv = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (!(cur_pt.drain && expected_pts.size() != 0)) begin
        nv = 1'b1;
        pt_up = 1'b1;
      end
    end
    pt_in_ch.valid <= nv;
    if (nv) begin
      pt_in_ch.point_x <= cur_pt.x;
      pt_in_ch.point_y <= cur_pt.y;
      pt_in_ch.final_point <= cur_pt.fin;
    end else begin
      pt_in_ch.point_x <= $urandom;
      pt_in_ch.point_y <= $urandom;
      pt_in_ch.final_point <= 1'($urandom_range(0, 1));
    end
  end

  // Stall the output side for a random count of valid cycles per beat
  always @(negedge clk) begin
    if (beat_taken) begin
      beat_taken = 1'b0;
      ready_wait = calm ? 0 : $urandom_range(0, 9);
    end
    if (ready_wait != 0) begin
      pt_out_ch.ready <= 1'b0;
      if (pt_out_ch.valid) begin
        ready_wait--;
      end
    end else begin
      pt_out_ch.ready <= 1'b1;
    end
  end

  // Predict on accepted points, check accepted beats, watch for a hang
  always @(posedge clk) begin
    bit      moved;
    out_pt_t want;
    moved = 1'b0;
    if (!rst) begin
      if (pt_in_ch.valid && pt_in_ch.ready) begin
        predict_point(pt_in_ch.point_x, pt_in_ch.point_y, pt_in_ch.final_point);
        pt_taken = 1'b1;
        moved = 1'b1;
      end
      if (pt_out_ch.valid && pt_out_ch.ready) begin
        beat_taken = 1'b1;
        moved = 1'b1;
        if (expected_pts.size() == 0) begin
          $error("unexpected beat: out_x %0d out_y %0d run_end %0b",
                 pt_out_ch.out_x, pt_out_ch.out_y, pt_out_ch.run_end);
          fail_count++;
        end else begin
          want = expected_pts.pop_front();
          if (pt_out_ch.out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, pt_out_ch.out_x);
            fail_count++;
          end
          if (pt_out_ch.out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, pt_out_ch.out_y);
            fail_count++;
          end
          if (pt_out_ch.run_end !== want.run_end) begin
            $error("run_end: expected %0b, got %0b", want.run_end, pt_out_ch.run_end);
            fail_count++;
          end
        end
      end
    end
    idle_run = moved ? 0 : idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [FAC_W-1:0] fac;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pt_in_ch.valid = 1'b0;
    pt_in_ch.point_x = '0;
    pt_in_ch.point_y = '0;
    pt_in_ch.final_point = 1'b0;
    pt_out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: extremes of both coordinates, full-scale swings
    stage_pt(32'sd0, 32'sd0, 1'b0, 1'b0);
    stage_pt(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    stage_pt(32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
    stage_pt(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0);
    stage_pt(-32'sd1, 32'sd1, 1'b1, 1'b0);
    settle();

    // Nearest at the top factor, then a single-point series
    set_config(MODE_NEAREST, 6'd32);
    stage_pt(32'sd100, -32'sd100, 1'b0, 1'b0);
    stage_pt(-32'sd100, 32'sd100, 1'b1, 1'b0);
    stage_pt(32'sd5, 32'sd5, 1'b1, 1'b0);
    settle();

    // Zero fill at factor one: only stored points and the final point come out
    set_config(MODE_ZERO, 6'd1);
    stage_pt(32'sd1, 32'sd2, 1'b0, 1'b0);
    stage_pt(32'sd3, 32'sd4, 1'b0, 1'b0);
    stage_pt(32'sd5, 32'sd6, 1'b1, 1'b0);
    settle();

    // Reserved mode acts as linear; factor zero acts as one
    set_config(MODE_RESERVED, 6'd0);
    stage_pt(32'sd10, 32'sd10, 1'b0, 1'b0);
    stage_pt(32'sd20, -32'sd20, 1'b1, 1'b0);
    settle();

    // Factor above the maximum saturates
    set_config(MODE_LINEAR, 6'd63);
    stage_pt(32'sd0, 32'sd0, 1'b0, 1'b0);
    stage_pt(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    stage_pt(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b0);
    settle();

    // Small negative steps check truncation toward zero
    set_config(MODE_LINEAR, 6'd33);
    stage_pt(32'sd0, 32'sd0, 1'b0, 1'b0);
    stage_pt(32'sd3, -32'sd3, 1'b1, 1'b0);
    settle();

    // No idling, and one point held back until the output drains
    calm = 1'b1;
    set_config(MODE_LINEAR, 6'd7);
    stage_pt(32'sd1000, -32'sd1000, 1'b0, 1'b0);
    stage_pt(-32'sd999, 32'sd999, 1'b0, 1'b0);
    stage_pt(32'sd7, 32'sd7, 1'b1, 1'b1);
    settle();

    // Random phases: mostly small factors, a few large or out of range
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: fac = 6'd0;
        1: fac = FAC_W'($urandom_range(9, 63));
        default: fac = FAC_W'($urandom_range(1, 8));
      endcase
      set_config(MODE_W'($urandom_range(0, 3)), fac);
      for (int n = 0; n < PHASE_POINTS; n++) begin
        stage_pt(rand_coord(), rand_coord(), $urandom_range(0, 5) == 0,
                 $urandom_range(0, 29) == 0);
      end
      settle();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_pts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
